FILE: hw/rtl/assert_macros.svh
// assertion macros for the checker file mbps_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with reset disable, expects clk and arst_n in scope
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression that must never be true
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

FILE: hw/rtl/mbps_pkg.sv
// shared constants and types for the masked byte pattern search unit
package mbps_pkg;

	localparam int MAX_PATTERN_DEF = 16;
	localparam int OFFSET_BITS_DEF = 32;

	localparam int BYTE_W     = 8;
	localparam int ADDR_W     = 64;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CARE_W     = 16;
	localparam int PLEN_W     = 5;
	localparam int PAT_BYTES  = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAT_LO = 3'd0,
		CFG_PAT_HI = 3'd1,
		CFG_CARE   = 3'd2,
		CFG_LEN    = 3'd3,
		CFG_BASE   = 3'd4
	} cfg_reg_t;

	// pattern settings fanned out to every cell
	typedef struct packed {
		logic [PAT_BYTES*BYTE_W-1:0] pattern;
		logic [CARE_W-1:0]           care;
	} match_cfg_t;

endpackage

FILE: hw/rtl/mbps_if.sv
// valid/ready channels for scanned bytes and search results
interface mbps_scan_if;
	import mbps_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_region;

	modport source (output valid, output data_byte, output end_of_region, input ready);
	modport sink   (input valid, input data_byte, input end_of_region, output ready);
endinterface

interface mbps_result_if;
	import mbps_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [ADDR_W-1:0] match_address;

	modport source (output valid, output found, output match_address, input ready);
	modport sink   (input valid, input found, input match_address, output ready);
endinterface

FILE: hw/rtl/masked_byte_pattern_search_unit.sv
// top level of the masked byte pattern search unit
// Usage:
//   scan   : byte stream in, one data_byte per transaction, end_of_region set on
//            the last byte of a region
//   result : at most one transaction per region; found=1 with region_base plus
//            the start offset of the first match, or found=0 (address 0) when
//            the region ends without a match
//   cfg    : cfg_we/cfg_index/cfg_wdata write pattern low/high, care mask,
//            length and region base; write only while no bytes are in flight
// Throughput: one byte per cycle unless a result waits. A row of MAX_PATTERN cells
// shifts the window and each cell compares its byte in the cycle the byte moves in.
// Pipeline: the cell compares are registered at the edge that accepts a byte and
// the reduce/add lands in the output register when the pipe advances again.
// Reset: window counter and match flag clear, registers take their defaults
// (care all ones, length one); no clearing pass is needed.
// Stall: while a result waits unaccepted the whole pipe holds and scan.ready is
// low; with the output register empty or being drained, bytes flow every cycle.
module masked_byte_pattern_search_unit #(
	parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF,
	parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mbps_scan_if.sink                      scan,
	mbps_result_if.source                  result,
	input  logic                           cfg_we,
	input  logic [mbps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mbps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	// configuration registers
	logic [63:0]        pat_lo_q;
	logic [63:0]        pat_hi_q;
	logic [CARE_W-1:0]  care_q;
	logic [PLEN_W-1:0]  plen_q;
	logic [ADDR_W-1:0]  base_q;

	// control state
	logic [OFFSET_BITS-1:0] seen_q;
	logic                   reported_q;

	// stage 1: cell compares and offset
	logic                   valid_s1;
	logic                   last_s1;
	logic                   ok_s1;
	logic [OFFSET_BITS-1:0] offset_s1;

	// output register
	logic              out_valid_q;
	logic              found_q;
	logic [ADDR_W-1:0] addr_q;

	logic                   advance;
	logic                   accept;
	logic [LEN_W-1:0]       eff_len;
	logic                   cnt_ok;
	logic [OFFSET_BITS-1:0] seen_inc;
	logic [OFFSET_BITS-1:0] len_ext;
	match_cfg_t             mcfg;
	logic [BYTE_W-1:0]      window [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] hit_s1;
	logic                   fire;
	logic                   miss;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo_q <= '0;
			pat_hi_q <= '0;
			care_q   <= '1;
			plen_q   <= PLEN_W'(1);
			base_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PAT_LO: pat_lo_q <= cfg_wdata;
				CFG_PAT_HI: pat_hi_q <= cfg_wdata;
				CFG_CARE:   care_q   <= cfg_wdata[CARE_W-1:0];
				CFG_LEN:    plen_q   <= cfg_wdata[PLEN_W-1:0];
				CFG_BASE:   base_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// effective length: zero acts as one, clamp to the window depth
	always_comb begin
		if (plen_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(plen_q) > MAX_PATTERN) begin
			eff_len = LEN_W'(MAX_PATTERN);
		end else begin
			eff_len = LEN_W'(plen_q);
		end
	end

	assign mcfg.pattern = {pat_hi_q, pat_lo_q};
	assign mcfg.care    = care_q;

	// whole pipe moves together; it holds only while a result waits
	assign advance      = !out_valid_q || result.ready;
	assign scan.ready   = advance;
	assign accept       = scan.valid && advance;

	// saturating byte counter, offset becomes unrepresentable at all ones
	assign cnt_ok   = seen_q != '1;
	assign seen_inc = seen_q + OFFSET_BITS'(1);
	assign len_ext  = OFFSET_BITS'(eff_len);

	// row of window cells, cell 0 takes the newest byte
	for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
		logic [BYTE_W-1:0] cell_in;
		if (k == 0) begin : g_head
			assign cell_in = scan.data_byte;
		end else begin : g_link
			assign cell_in = window[k-1];
		end
		mbps_cell #(
			.INDEX (k),
			.LEN_W (LEN_W)
		) u_cell (
			.clk      (clk),
			.en       (accept),
			.byte_in  (cell_in),
			.eff_len  (eff_len),
			.cfg      (mcfg),
			.window_q (window[k]),
			.hit_s1   (hit_s1[k])
		);
	end

	// stage 1 control and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			seen_q   <= '0;
		end else if (advance) begin
			valid_s1 <= scan.valid;
			if (scan.valid) begin
				if (scan.end_of_region) begin
					seen_q <= '0;
				end else if (cnt_ok) begin
					seen_q <= seen_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= scan.end_of_region;
			ok_s1     <= cnt_ok && (seen_inc >= len_ext);
			offset_s1 <= seen_inc - len_ext;
		end
	end

	// stage 2: all cells agree, no earlier match in region; or a miss at region end
	assign fire = valid_s1 && ok_s1 && (&hit_s1) && !reported_q;
	assign miss = valid_s1 && last_s1 && !reported_q && !fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			reported_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire || miss;
			if (valid_s1 && last_s1) begin
				reported_q <= 1'b0;
			end else if (fire) begin
				reported_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (fire) begin
				found_q <= 1'b1;
				addr_q  <= base_q + ADDR_W'(offset_s1);
			end else begin
				found_q <= 1'b0;
				addr_q  <= '0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.found         = found_q;
	assign result.match_address = addr_q;

endmodule

FILE: hw/rtl/mbps_cell.sv
// one window cell: holds a byte, passes it on, registers its masked compare
module mbps_cell #(
	parameter int INDEX = 0,
	parameter int LEN_W = 5
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [mbps_pkg::BYTE_W-1:0] byte_in,
	input  logic [LEN_W-1:0]           eff_len,
	input  mbps_pkg::match_cfg_t       cfg,
	output logic [mbps_pkg::BYTE_W-1:0] window_q,
	output logic                       hit_s1
);
	import mbps_pkg::*;

	logic [LEN_W-1:0]  pos;
	logic [3:0]        sel;
	logic              in_use;
	logic              cares;
	logic [BYTE_W-1:0] want;
	logic              hit;

	// pattern position that lands on this cell: len - 1 - INDEX
	assign pos    = eff_len - LEN_W'(INDEX + 1);
	assign sel    = 4'(pos);
	assign in_use = 32'(eff_len) > INDEX;
	assign cares  = in_use && (32'(pos) < PAT_BYTES) && cfg.care[sel];
	assign want   = cfg.pattern[sel*BYTE_W +: BYTE_W];
	assign hit    = !cares || (byte_in == want);

	always_ff @(posedge clk) begin
		if (en) begin
			window_q <= byte_in;
			hit_s1   <= hit;
		end
	end

endmodule

FILE: hw/rtl/mbps_checker.sv
// port-level checker for the masked byte pattern search unit, with its bind
`include "assert_macros.svh"

module mbps_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         scan_ready,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic                         res_found,
	input logic [mbps_pkg::ADDR_W-1:0]  res_addr
);
	import mbps_pkg::*;

	// a stalled result keeps its contents
	`ASSERT_CLK(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_found) && $stable(res_addr), "result changed while stalled")

	// a not-found transaction carries address zero
	`ASSERT_NEVER(a_miss_addr, res_valid && !res_found && (res_addr != '0), "not-found result with nonzero address")

	// with the output register empty the block always takes bytes
	`ASSERT_NEVER(a_ready_idle, !res_valid && !scan_ready, "scan stalled with empty output")

	// a waiting result must stall the byte stream
	`ASSERT_NEVER(a_stall_prop, res_valid && !res_ready && scan_ready, "bytes taken while result stalled")

endmodule

bind masked_byte_pattern_search_unit mbps_checker u_mbps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.scan_ready (scan.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_found  (result.found),
	.res_addr   (result.match_address)
);
